// File: rtl/scs_pkg.sv
// shared types, constants and helpers for the stepper command sequencer
`timescale 1ns / 1ps

package scs_pkg;

  // command slots, in serving order
  localparam int CMD_DIR  = 0;
  localparam int CMD_FAST = 1;
  localparam int CMD_SLOW = 2;
  localparam int CMD_RUN  = 3;
  localparam int CMD_STAT = 4;
  localparam int NUM_CMD  = 5;

  // command bytes
  localparam logic [7:0] BYTE_DIR    = 8'h31;  // '1'
  localparam logic [7:0] BYTE_FAST   = 8'h32;  // '2'
  localparam logic [7:0] BYTE_SLOW   = 8'h33;  // '3'
  localparam logic [7:0] BYTE_RUN    = 8'h30;  // '0'
  localparam logic [7:0] BYTE_STAT_L = 8'h73;  // 's'
  localparam logic [7:0] BYTE_STAT_U = 8'h53;  // 'S'

  localparam logic [7:0] PEND_MAX       = 8'd250;
  localparam logic [7:0] RST_PERIOD     = 8'd200;
  localparam logic [6:0] RST_STEP       = 7'd30;
  localparam logic [7:0] RST_FAST_LIMIT = 8'd140;
  localparam logic [7:0] RST_SLOW_LIMIT = 8'd220;

  // configuration register indexes
  localparam logic [7:0] REG_START_PERIOD = 8'd0;
  localparam logic [7:0] REG_PERIOD_STEP  = 8'd1;
  localparam logic [7:0] REG_FAST_LIMIT   = 8'd2;
  localparam logic [7:0] REG_SLOW_LIMIT   = 8'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int OUT_DATA_W = 24;

  // classified item as it waits in the queue
  typedef struct packed {
    logic               is_tick;
    logic [NUM_CMD-1:0] cmd_sel;  // one-hot, all zero for an ignored byte
  } scs_item_t;

  // forward coil order; reverse walks the same table backward
  function automatic logic [3:0] coil_pattern(input logic fwd, input logic [1:0] phase);
    logic [1:0] idx;
    logic [3:0] pat;
    idx = fwd ? phase : ~phase;
    case (idx)
      2'd0:    pat = 4'hD;
      2'd1:    pat = 4'h7;
      2'd2:    pat = 4'hE;
      2'd3:    pat = 4'hB;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

// File: rtl/scs_front.sv
// front end: accepts input beats and classifies them into queue items
`timescale 1ns / 1ps

module scs_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] rx_byte
  input  logic              in_tuser,   // [0] mode
  input  logic              q_full,
  output logic              q_push,
  output scs_pkg::scs_item_t q_item
);

  always_comb begin
    q_item = '0;
    q_item.is_tick = in_tuser;
    if (!in_tuser) begin
      q_item.cmd_sel[scs_pkg::CMD_DIR]  = (in_tdata == scs_pkg::BYTE_DIR);
      q_item.cmd_sel[scs_pkg::CMD_FAST] = (in_tdata == scs_pkg::BYTE_FAST);
      q_item.cmd_sel[scs_pkg::CMD_SLOW] = (in_tdata == scs_pkg::BYTE_SLOW);
      q_item.cmd_sel[scs_pkg::CMD_RUN]  = (in_tdata == scs_pkg::BYTE_RUN);
      q_item.cmd_sel[scs_pkg::CMD_STAT] = (in_tdata == scs_pkg::BYTE_STAT_L) ||
                                          (in_tdata == scs_pkg::BYTE_STAT_U);
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

// File: rtl/scs_queue.sv
// short queue between the classifying front end and the executing back end
`timescale 1ns / 1ps

module scs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scs_pkg::scs_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output scs_pkg::scs_item_t q_item
);

  scs_pkg::scs_item_t mem_r [scs_pkg::QUEUE_DEPTH];

  logic [scs_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [scs_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [scs_pkg::QPTR_W:0]   count_r, count_nxt;
  logic                       do_pop;

  assign full    = (count_r == (scs_pkg::QPTR_W+1)'(scs_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // occupancy follows the pointer distance
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[scs_pkg::QPTR_W-1:0] == (wr_ptr_r - rd_ptr_r)))
    else $error("queue count out of step with pointers");

endmodule

// File: rtl/scs_back.sv
// back end: pending counters, motor state, config registers and result beat
`timescale 1ns / 1ps

module scs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  scs_pkg::scs_item_t q_item,
  output logic               q_pop,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [scs_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [6:0] step_r;
  logic [7:0] fast_lim_r;
  logic [7:0] slow_lim_r;

  logic [7:0] pend_r [scs_pkg::NUM_CMD];
  logic [7:0] pend_nxt [scs_pkg::NUM_CMD];
  logic [7:0] period_r, period_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       dir_r, dir_nxt;
  logic       run_r, run_nxt;
  logic [3:0] coil_r, coil_nxt;
  logic [3:0] ev_nxt;

  logic                          out_valid_r;
  logic [scs_pkg::OUT_DATA_W-1:0] out_data_r;

  logic       take;
  logic       do_serve;
  logic [7:0] period_fast;
  logic [8:0] slow_sum;
  logic [7:0] hold_inc;

  assign take  = q_valid && (!out_valid_r || out_tready);
  assign q_pop = take;

  always_comb begin
    for (int i = 0; i < scs_pkg::NUM_CMD; i++) begin
      pend_nxt[i] = pend_r[i];
    end
    period_nxt  = period_r;
    phase_nxt   = phase_r;
    hold_nxt    = hold_r;
    dir_nxt     = dir_r;
    run_nxt     = run_r;
    coil_nxt    = coil_r;
    ev_nxt      = '0;
    do_serve    = !run_r || (phase_r == 2'd0 && hold_r == 8'd0);
    period_fast = period_r;
    slow_sum    = '0;
    hold_inc    = '0;

    if (take && !q_item.is_tick) begin
      for (int i = 0; i < scs_pkg::NUM_CMD; i++) begin
        if (q_item.cmd_sel[i] && pend_r[i] < scs_pkg::PEND_MAX) begin
          pend_nxt[i] = pend_r[i] + 8'd1;
        end
      end
    end else if (take) begin
      if (do_serve) begin
        for (int i = 0; i < scs_pkg::NUM_CMD; i++) begin
          if (pend_r[i] != 8'd0) begin
            pend_nxt[i] = pend_r[i] - 8'd1;
          end
        end
        if (pend_r[scs_pkg::CMD_DIR] != 8'd0) begin
          dir_nxt   = !dir_r;
          ev_nxt[0] = 1'b1;
        end
        // speed up, then slow down on the updated period
        if (pend_r[scs_pkg::CMD_FAST] != 8'd0) begin
          ev_nxt[1] = 1'b1;
          if (period_r >= fast_lim_r) begin
            period_fast = (period_r > {1'b0, step_r}) ? period_r - {1'b0, step_r} : 8'd1;
          end
        end
        period_nxt = period_fast;
        if (pend_r[scs_pkg::CMD_SLOW] != 8'd0) begin
          ev_nxt[1] = 1'b1;
          if (period_fast <= slow_lim_r) begin
            slow_sum   = {1'b0, period_fast} + {2'b00, step_r};
            period_nxt = slow_sum[8] ? 8'hFF : slow_sum[7:0];
          end
        end
        if (pend_r[scs_pkg::CMD_RUN] != 8'd0) begin
          ev_nxt[2] = 1'b1;
          if (run_r) begin
            run_nxt   = 1'b0;
            phase_nxt = 2'd0;
            hold_nxt  = 8'd0;
          end else begin
            run_nxt = 1'b1;
          end
        end
        if (pend_r[scs_pkg::CMD_STAT] != 8'd0) begin
          ev_nxt[3] = 1'b1;
        end
      end
      if (run_nxt) begin
        coil_nxt = scs_pkg::coil_pattern(dir_nxt, phase_nxt);
        hold_inc = hold_nxt + 8'd1;
        if (hold_inc >= period_nxt) begin
          hold_nxt  = 8'd0;
          phase_nxt = phase_nxt + 2'd1;
        end else begin
          hold_nxt = hold_inc;
        end
      end else begin
        coil_nxt  = 4'h0;
        phase_nxt = 2'd0;
        hold_nxt  = 8'd0;
      end
    end

    // start period write reloads the live period, zero reads as one
    if (cfg_valid && cfg_index == scs_pkg::REG_START_PERIOD) begin
      period_nxt = (cfg_data == 8'd0) ? 8'd1 : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < scs_pkg::NUM_CMD; i++) begin
        pend_r[i] <= '0;
      end
      period_r    <= scs_pkg::RST_PERIOD;
      phase_r     <= '0;
      hold_r      <= '0;
      dir_r       <= 1'b1;
      run_r       <= 1'b1;
      coil_r      <= '0;
      step_r      <= scs_pkg::RST_STEP;
      fast_lim_r  <= scs_pkg::RST_FAST_LIMIT;
      slow_lim_r  <= scs_pkg::RST_SLOW_LIMIT;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < scs_pkg::NUM_CMD; i++) begin
        pend_r[i] <= pend_nxt[i];
      end
      period_r <= period_nxt;
      phase_r  <= phase_nxt;
      hold_r   <= hold_nxt;
      dir_r    <= dir_nxt;
      run_r    <= run_nxt;
      coil_r   <= coil_nxt;
      if (cfg_valid && cfg_index == scs_pkg::REG_PERIOD_STEP) begin
        step_r <= cfg_data[6:0];
      end
      if (cfg_valid && cfg_index == scs_pkg::REG_FAST_LIMIT) begin
        fast_lim_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == scs_pkg::REG_SLOW_LIMIT) begin
        slow_lim_r <= cfg_data;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {6'd0, ev_nxt, period_nxt, dir_nxt, run_nxt, coil_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (period_r != 8'd0))
    else $error("period reached zero");

  a_stopped_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
    (!run_r |-> (coil_r == 4'h0 && phase_r == 2'd0 && hold_r == 8'd0)))
    else $error("coils driven while stopped");

  a_pend_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r[scs_pkg::CMD_DIR] <= scs_pkg::PEND_MAX &&
     pend_r[scs_pkg::CMD_STAT] <= scs_pkg::PEND_MAX))
    else $error("pending counter above saturation");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

endmodule

// File: rtl/stepper_command_sequencer.sv
// top level of the four-coil stepper command sequencer
`timescale 1ns / 1ps

// Each input beat is either a command byte (in_tuser = 0) or one time tick
// (in_tuser = 1), and every beat yields exactly one result beat with the
// coil drive, run and direction state, the current period and the events
// served by that beat. The block takes one beat per clock while its queue is
// not full: a four-entry queue sits between the classifier and the execution
// stage, and the execution stage updates the counters and motor state
// combinationally into an output register, so a result passes through the
// queue and the output register and is held there while the output is stalled.
// Configuration writes are always ready and take effect on the next clock; a
// start_period write also reloads the live period.

module stepper_command_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] coils, [4] running, [5] forward, [13:6] period_now,
  // [14] direction_event, [15] speed_event, [16] run_event,
  // [17] status_event, [23:18] zero
  output logic [scs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_valid;
  scs_pkg::scs_item_t push_item;
  scs_pkg::scs_item_t q_item;

  assign cfg_ready = 1'b1;

  scs_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  scs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  scs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
